// ----- rtl/core/pcps_pkg.sv -----
// pcps_pkg: shared types and constants for the point charge potential sum.
// No dependencies.
package pcps_pkg;

  localparam int unsigned MaxCharges = 256;
  localparam int unsigned IdxW       = (MaxCharges > 1) ? $clog2(MaxCharges) : 1;
  localparam int unsigned CntW       = $clog2(MaxCharges + 1);

  localparam int unsigned PosW = 32;
  localparam int unsigned ChgW = 24;
  localparam int unsigned PotW = 40;
  localparam int unsigned AccW = 72;

  typedef logic [1:0] action_t;
  typedef logic [1:0] status_t;

  localparam action_t ActLoad  = 2'd0;
  localparam action_t ActClear = 2'd1;

  localparam status_t StPotential = 2'd0;
  localparam status_t StLoaded    = 2'd1;
  localparam status_t StFull      = 2'd2;
  localparam status_t StCleared   = 2'd3;

  // one stored charge entry
  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
    logic signed [ChgW-1:0] q;
  } entry_t;

endpackage

// ----- rtl/core/pcps_if.sv -----
// pcps_item_if / pcps_result_if: valid/ready channels for input and result words.
// Depends on pcps_pkg.
interface pcps_item_if;
  import pcps_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             action;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic signed [PosW-1:0] pos_z;
  logic signed [ChgW-1:0] charge;
  modport source (output valid, action, pos_x, pos_y, pos_z, charge, input ready);
  modport sink   (input valid, action, pos_x, pos_y, pos_z, charge, output ready);
endinterface

interface pcps_result_if;
  import pcps_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic signed [PotW-1:0] potential;
  logic                   saturated;
  modport source (output valid, status, potential, saturated, input ready);
  modport sink   (input valid, status, potential, saturated, output ready);
endinterface

// ----- rtl/core/point_charge_potential_sum.sv -----
// point_charge_potential_sum: charge table plus a sequenced potential evaluator.
// Depends on pcps_pkg and the channel interfaces in pcps_if.sv.
//
// Usage:
//   in_i carries one word per item: action, pos_x/y/z, charge. out_o returns
//   exactly one word per item: status, potential, saturated.
//   Load (action 0) appends to the table, or reports table full. Clear
//   (action 1) drops the count only. Evaluate (action 2 or 3) returns
//   -sum q*min(v_max, 1/d) over the stored charges, Q24.16, saturated.
//   v_max is written through v_max_we_i / v_max_i; the user must do so only
//   while the block is idle, and the block itself leaves this unchecked.
// Timing:
//   Load and clear: result word in the cycle after accept.
//   Evaluate, per stored charge: one table read, one 32x32 squarer taking the
//   three axes in turn, one check, a bit-serial restoring divider for 2^64/S,
//   a bit-serial integer square root, one multiply-accumulate step. A charge
//   at zero distance, at 2^-16 Bohr or at 2^16 Bohr and beyond skips divider
//   and root. in_i.ready is high only while idle with no result word waiting.
// Reset: count zero, v_max all ones, no result pending. The table contents are
//   not cleared. A stalled out_o holds the word and keeps in_i not ready.
module point_charge_potential_sum (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      v_max_we_i,
  input  logic [31:0]               v_max_i,
  pcps_item_if.sink                 in_i,
  pcps_result_if.source             out_o
);
  import pcps_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRd   = 3'd1;
  localparam logic [2:0] StSq   = 3'd2;
  localparam logic [2:0] StChk  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StSqr  = 3'd5;
  localparam logic [2:0] StMac  = 3'd6;
  localparam logic [2:0] StOut  = 3'd7;

  logic [2:0]      state_q, state_d;
  logic [31:0]     vmax_q;
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] idx_q;
  logic            last_q;     // current entry is the last one
  entry_t          mem [MaxCharges];
  entry_t          ent_q;
  logic signed [PosW-1:0] px_q, py_q, pz_q;

  logic [1:0]      k_q;        // squarer axis
  logic [65:0]     s_q;        // squared distance, 2^-32 units
  logic [64:0]     rem_q;      // divider remainder
  logic [64:0]     quo_q;      // divider quotient / root source
  logic [6:0]      cnt_q;
  logic [35:0]     srem_q;
  logic [32:0]     root_q;
  logic [32:0]     v_q;
  logic signed [AccW-1:0] acc_q;

  logic [1:0]             st_q;
  logic signed [PotW-1:0] pot_q;
  logic                   sat_q;
  logic                   ovalid_q;

  logic accept;
  assign accept       = in_i.valid && in_i.ready;
  assign in_i.ready   = (state_q == StIdle) && !ovalid_q;
  assign out_o.valid  = ovalid_q;
  assign out_o.status = st_q;
  assign out_o.potential = pot_q;
  assign out_o.saturated = sat_q;

  // squarer datapath, one axis per cycle
  logic signed [PosW:0] dq, de, diff;
  logic [PosW-1:0]      mag;
  logic [63:0]          sq;
  always_comb begin
    dq = {px_q[PosW-1], px_q};
    de = {ent_q.x[PosW-1], ent_q.x};
    case (k_q)
      2'd1: begin
        dq = {py_q[PosW-1], py_q};
        de = {ent_q.y[PosW-1], ent_q.y};
      end
      2'd2: begin
        dq = {pz_q[PosW-1], pz_q};
        de = {ent_q.z[PosW-1], ent_q.z};
      end
      default: ;
    endcase
    diff = dq - de;
    mag  = diff[PosW] ? PosW'(-diff) : diff[PosW-1:0];
    sq   = 64'(mag) * 64'(mag);
  end

  // divider step
  logic [64:0] rem_sh, rem_sub;
  logic        div_ge;
  always_comb begin
    rem_sh  = {rem_q[63:0], (cnt_q == 7'd64)};
    div_ge  = rem_sh >= {1'b0, s_q[63:0]};
    rem_sub = rem_sh - {1'b0, s_q[63:0]};
  end

  // square root step
  logic [35:0] srem_sh, trial;
  logic        sqr_ge;
  always_comb begin
    srem_sh = {srem_q[33:0], quo_q[64:63]};
    trial   = {1'b0, root_q, 2'b01};
    sqr_ge  = srem_sh >= trial;
  end

  // multiply-accumulate and final rounding
  logic signed [57:0]     prod;
  logic signed [AccW-1:0] rnd;
  logic signed [55:0]     shr;
  logic                   fits;
  always_comb begin
    prod = 58'(ent_q.q) * $signed({25'd0, v_q});
    rnd  = acc_q + AccW'(32768);
    shr  = rnd[AccW-1:16];
    fits = (shr[55:PotW-1] == '0) || (shr[55:PotW-1] == '1);
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (accept && in_i.action == ActLoad && count_q < CntW'(MaxCharges)) begin
      mem[count_q[IdxW-1:0]] <= '{x: in_i.pos_x, y: in_i.pos_y, z: in_i.pos_z,
                                  q: in_i.charge};
    end
    ent_q <= mem[idx_q];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept) begin
        if (in_i.action[1] && count_q != '0) state_d = StRd;
        else if (in_i.action[1]) state_d = StOut;
      end
      StRd:  state_d = StSq;
      StSq:  if (k_q == 2'd2) state_d = StChk;
      StChk: state_d = (s_q == '0 || s_q == 66'd1 || s_q[65:64] != '0) ? StMac : StDiv;
      StDiv: if (cnt_q == '0) state_d = StSqr;
      StSqr: if (cnt_q == '0) state_d = StMac;
      StMac: state_d = last_q ? StOut : StRd;
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      vmax_q   <= '1;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (v_max_we_i) vmax_q <= v_max_i;
      if (out_o.valid && out_o.ready) ovalid_q <= 1'b0;
      if (state_q == StOut) ovalid_q <= 1'b1;
      if (state_q == StIdle && accept && !in_i.action[1]) begin
        ovalid_q <= 1'b1;
        if (in_i.action == ActClear) count_q <= '0;
        else if (count_q < CntW'(MaxCharges)) count_q <= count_q + 1'b1;
      end
      // hold off the evaluator's own result until the previous word leaves
      if (state_q == StOut && ovalid_q && !out_o.ready) state_q <= StOut;
      else state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: if (accept) begin
        px_q   <= in_i.pos_x;
        py_q   <= in_i.pos_y;
        pz_q   <= in_i.pos_z;
        idx_q  <= '0;
        last_q <= (count_q == CntW'(1));
        acc_q  <= '0;
        if (!in_i.action[1]) begin
          pot_q <= '0;
          sat_q <= 1'b0;
          if (in_i.action == ActClear) st_q <= StCleared;
          else st_q <= (count_q < CntW'(MaxCharges)) ? StLoaded : StFull;
        end
      end
      StRd: begin
        k_q <= 2'd0;
        s_q <= '0;
      end
      StSq: begin
        s_q <= s_q + 66'(sq);
        k_q <= k_q + 2'd1;
      end
      StChk: begin
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= 7'd64;
        // zero distance, and 1/d = 2^32 above any cap, both give v_max
        if (s_q == '0 || s_q == 66'd1) v_q <= {1'b0, vmax_q};
        else v_q <= (s_q == 66'h1_0000_0000_0000_0000 && vmax_q != '0) ? 33'd1 : 33'd0;
      end
      StDiv: begin
        rem_q <= div_ge ? rem_sub : rem_sh;
        quo_q <= {quo_q[63:0], div_ge};
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == '0) begin
          cnt_q  <= 7'd31;
          srem_q <= '0;
          root_q <= '0;
          // S >= 2 here, so the quotient fits 64 bits: left-align it
          quo_q  <= {quo_q[62:0], div_ge, 1'b0};
        end
      end
      StSqr: begin
        srem_q <= sqr_ge ? (srem_sh - trial) : srem_sh;
        root_q <= {root_q[31:0], sqr_ge};
        quo_q  <= {quo_q[62:0], 2'b00};
        cnt_q  <= cnt_q - 7'd1;
        if (cnt_q == '0) begin
          v_q <= ({root_q[31:0], sqr_ge} > {1'b0, vmax_q}) ? {1'b0, vmax_q}
                                                         : {root_q[31:0], sqr_ge};
        end
      end
      StMac: begin
        acc_q  <= acc_q - AccW'(prod);
        idx_q  <= idx_q + 1'b1;
        last_q <= (CntW'(idx_q) + CntW'(2) == count_q);
      end
      StOut: if (!(ovalid_q && !out_o.ready)) begin
        st_q  <= StPotential;
        sat_q <= !fits;
        pot_q <= fits ? shr[PotW-1:0] : (shr[55] ? {1'b1, {(PotW-1){1'b0}}}
                                                 : {1'b0, {(PotW-1){1'b1}}});
      end
      default: ;
    endcase
  end

endmodule
